[hw/rtl/rgb_to_hsv_pixel_assert.svh]
// Assertion macros for the rgb_to_hsv_pixel RTL, included by rhp_div_pipe.
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define RHP_ASSERT_HOLDS(lbl, ck, rst_n, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RHP_ASSERT_IMPLIES(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/rhp_pkg.sv]
// Package: default widths for the RGB to HSV pixel converter.
`default_nettype none

package rhp_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int FRACTION_BITS_DEF = 16;

endpackage

`default_nettype wire

[hw/rtl/rhp_div_pipe.sv]
// Pipelined restoring dividers for saturation and hue, one quotient bit per stage.
`default_nettype none

`include "rgb_to_hsv_pixel_assert.svh"

module rhp_div_pipe #(
	parameter int CHANNEL_BITS  = rhp_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhp_pkg::FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CHANNEL_BITS-1:0]   sat_num,
	input  logic [CHANNEL_BITS-1:0]   sat_den,
	input  logic [CHANNEL_BITS+3:0]   hue_num,
	input  logic [CHANNEL_BITS+2:0]   hue_den,
	input  logic [CHANNEL_BITS-1:0]   val,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [FRACTION_BITS-1:0]  hue,
	output logic [FRACTION_BITS:0]    saturation,
	output logic [CHANNEL_BITS-1:0]   brightness
);
	import rhp_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int FB = FRACTION_BITS;
	// saturation needs FB+1 quotient bits, hue FB; hue skips the first stage
	localparam int NS = FB + 1;
	localparam logic [FB:0] SAT_ONE = {1'b1, {FB{1'b0}}};

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [CB:0]   srem_s [NS];
	logic [CB-1:0] sden_s [NS];
	logic [FB:0]   squo_s [NS];
	logic [CB+3:0] hrem_s [NS];
	logic [CB+2:0] hden_s [NS];
	logic [FB-1:0] hquo_s [NS];
	logic [CB-1:0] val_s  [NS];

	logic          src_vld  [NS];
	logic [CB:0]   src_srem [NS];
	logic [CB-1:0] src_sden [NS];
	logic [FB:0]   src_squo [NS];
	logic [CB+3:0] src_hrem [NS];
	logic [CB+2:0] src_hden [NS];
	logic [FB-1:0] src_hquo [NS];
	logic [CB-1:0] src_val  [NS];

	logic [CB:0]   ssub [NS];
	logic          sbit [NS];
	logic [CB+3:0] hsub [NS];
	logic          hbit [NS];
	logic [CB:0]   srem_d [NS];
	logic [FB:0]   squo_d [NS];
	logic [CB+3:0] hrem_d [NS];
	logic [FB-1:0] hquo_d [NS];

	always_comb begin
		src_vld[0]  = in_valid;
		src_srem[0] = {1'b0, sat_num};
		src_sden[0] = sat_den;
		src_squo[0] = '0;
		src_hrem[0] = hue_num;
		src_hden[0] = hue_den;
		src_hquo[0] = '0;
		src_val[0]  = val;
		for (int j = 1; j < NS; j++) begin
			src_vld[j]  = vld_s[j-1];
			src_srem[j] = srem_s[j-1];
			src_sden[j] = sden_s[j-1];
			src_squo[j] = squo_s[j-1];
			src_hrem[j] = hrem_s[j-1];
			src_hden[j] = hden_s[j-1];
			src_hquo[j] = hquo_s[j-1];
			src_val[j]  = val_s[j-1];
		end
	end

	// remainder stays below twice the divisor, so one compare/subtract per bit
	always_comb begin
		for (int j = 0; j < NS; j++) begin
			sbit[j]   = (src_srem[j] >= {1'b0, src_sden[j]});
			ssub[j]   = src_srem[j] - {1'b0, src_sden[j]};
			srem_d[j] = sbit[j] ? {ssub[j][CB-1:0], 1'b0} : {src_srem[j][CB-1:0], 1'b0};
			squo_d[j] = {src_squo[j][FB-1:0], sbit[j]};

			hbit[j] = (src_hrem[j] >= {1'b0, src_hden[j]});
			hsub[j] = src_hrem[j] - {1'b0, src_hden[j]};
			if (j == 0) begin
				hrem_d[j] = src_hrem[j];
				hquo_d[j] = src_hquo[j];
			end else begin
				hrem_d[j] = hbit[j] ? {hsub[j][CB+2:0], 1'b0}
				                    : {src_hrem[j][CB+2:0], 1'b0};
				hquo_d[j] = {src_hquo[j][FB-2:0], hbit[j]};
			end
		end
	end

	// a stage loads when it is empty or its successor moves
	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || out_ready;
		for (int j = NS - 2; j >= 0; j--) begin
			adv[j] = !vld_s[j] || adv[j+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int j = 0; j < NS; j++) begin
				if (adv[j]) begin
					vld_s[j] <= src_vld[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NS; j++) begin
			if (adv[j]) begin
				srem_s[j] <= srem_d[j];
				sden_s[j] <= src_sden[j];
				squo_s[j] <= squo_d[j];
				hrem_s[j] <= hrem_d[j];
				hden_s[j] <= src_hden[j];
				hquo_s[j] <= hquo_d[j];
				val_s[j]  <= src_val[j];
			end
		end
	end

	assign in_ready   = adv[0];
	assign out_valid  = vld_s[NS-1];
	assign hue        = hquo_s[NS-1];
	assign saturation = squo_s[NS-1];
	assign brightness = val_s[NS-1];

	`RHP_ASSERT_IMPLIES(a_sat_range, clk, arst_n, out_valid, saturation <= SAT_ONE, "saturation above one")
	`RHP_ASSERT_IMPLIES(a_grey_hue, clk, arst_n, out_valid && (saturation == '0), hue == '0, "grey word with nonzero hue")
	`RHP_ASSERT_IMPLIES(a_full_stall, clk, arst_n, !in_ready, &vld_s, "input stalled with a bubble in the pipe")

endmodule

`default_nettype wire

[hw/rtl/rgb_to_hsv_pixel.sv]
// RGB to HSV pixel converter: top level with the min/max front stage.
`default_nettype none

// Converts one RGB pixel per clock to hue, saturation and value. Each word
// passes through the pipe in order: one front stage finds the max,
// min, chroma and hue sector numerator, then FRACTION_BITS+1 stages each
// retire one quotient bit of the saturation divider and, from the second of
// them on, one bit of the hue divider. A new word is taken every cycle;
// throughput drops only while out_ready is low, and each stage holds its
// word until the next stage frees, so bubbles are squeezed out.
module rgb_to_hsv_pixel #(
	parameter int CHANNEL_BITS  = rhp_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhp_pkg::FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CHANNEL_BITS-1:0]   red,
	input  logic [CHANNEL_BITS-1:0]   green,
	input  logic [CHANNEL_BITS-1:0]   blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [FRACTION_BITS-1:0]  hue,
	output logic [FRACTION_BITS:0]    saturation,
	output logic [CHANNEL_BITS-1:0]   brightness
);
	import rhp_pkg::*;

	localparam int CB = CHANNEL_BITS;

	logic [CB-1:0] vmax;
	logic [CB-1:0] vmin;
	logic [CB-1:0] chroma;
	logic [CB+3:0] r_w;
	logic [CB+3:0] g_w;
	logic [CB+3:0] b_w;
	logic [CB+3:0] c_w;
	logic [CB+3:0] c6;
	logic [CB+3:0] numer;
	logic [CB-1:0] sden;
	logic [CB+2:0] hden;

	logic          vld_s1;
	logic [CB-1:0] val_s1;
	logic [CB-1:0] snum_s1;
	logic [CB-1:0] sden_s1;
	logic [CB+3:0] hnum_s1;
	logic [CB+2:0] hden_s1;
	logic          core_ready;
	logic          load_s1;

	always_comb begin
		vmax = (red > green) ? red : green;
		vmax = (vmax > blue) ? vmax : blue;
		vmin = (red < green) ? red : green;
		vmin = (vmin < blue) ? vmin : blue;
		chroma = vmax - vmin;
		r_w = {4'b0, red};
		g_w = {4'b0, green};
		b_w = {4'b0, blue};
		c_w = {4'b0, chroma};
		c6  = (c_w << 2) + (c_w << 1);
		// sector numerator, already wrapped into [0, 6C)
		if (red == vmax) begin
			numer = (green >= blue) ? (g_w - b_w) : (c6 - (b_w - g_w));
		end else if (green == vmax) begin
			numer = b_w + (c_w << 1) - r_w;
		end else begin
			numer = r_w + (c_w << 2) - g_w;
		end
		// zero divisors become one; their numerators are zero then
		sden = (vmax == '0) ? CB'(1) : vmax;
		hden = (chroma == '0) ? (CB+3)'(1) : c6[CB+2:0];
	end

	assign load_s1  = !vld_s1 || core_ready;
	assign in_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			val_s1  <= vmax;
			snum_s1 <= chroma;
			sden_s1 <= sden;
			hnum_s1 <= {numer[CB+2:0], 1'b0};
			hden_s1 <= hden;
		end
	end

	rhp_div_pipe #(
		.CHANNEL_BITS  (CHANNEL_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vld_s1),
		.in_ready   (core_ready),
		.sat_num    (snum_s1),
		.sat_den    (sden_s1),
		.hue_num    (hnum_s1),
		.hue_den    (hden_s1),
		.val        (val_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for rgb_to_hsv_pixel: directed and random pixels checked against a scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import rhp_pkg::*;

	localparam int CH = CHANNEL_BITS_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam int RANDOM_PIXELS = 1600;
	localparam int BLOCK_PIXELS = 200;
	localparam int CYCLE_LIMIT = 400000;

	// Red, green, blue packed high to low: extremes, ties, greys, every hue sector
	// and the wrap of a negative hue numerator.
	localparam logic [3*CH-1:0] DIRECTED [24] = '{
		24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff, 24'h808080, 24'h010101,
		24'hff0001, 24'hc80a14, 24'h0a14c8, 24'h140ac8, 24'h0ac814,
		24'h14c80a, 24'h000703, 24'h010000, 24'h000001, 24'h020100,
		24'hfffefe, 24'hff00fe, 24'haa55aa, 24'h55aa55
	};

	class hsv_scoreboard;
		typedef struct {
			logic [FB-1:0] hue;
			logic [FB:0]   saturation;
			logic [CH-1:0] brightness;
		} hsv_t;

		hsv_t expected_hsv[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		function hsv_t convert(logic [CH-1:0] r, logic [CH-1:0] g, logic [CH-1:0] b);
			hsv_t   px;
			longint vmax;
			longint vmin;
			longint chroma;
			longint num;
			vmax = (r > g) ? r : g;
			vmax = (vmax > b) ? vmax : b;
			vmin = (r < g) ? r : g;
			vmin = (vmin < b) ? vmin : b;
			chroma = vmax - vmin;
			px.brightness = vmax[CH-1:0];
			px.saturation = '0;
			px.hue = '0;
			if (vmax != 0)
				px.saturation = (FB+1)'((chroma << FB) / vmax);
			if (chroma != 0) begin
				// red wins ties, then green
				if (vmax == r)
					num = longint'(g) - longint'(b);
				else if (vmax == g)
					num = longint'(b) - longint'(r) + 2 * chroma;
				else
					num = longint'(r) - longint'(g) + 4 * chroma;
				if (num < 0)
					num += 6 * chroma;
				px.hue = FB'((num << FB) / (6 * chroma));
			end
			return px;
		endfunction

		function void note_pixel(logic [CH-1:0] r, logic [CH-1:0] g, logic [CH-1:0] b);
			expected_hsv.push_back(convert(r, g, b));
		endfunction

		function void check_pixel(logic [FB-1:0] h, logic [FB:0] s, logic [CH-1:0] v);
			hsv_t want;
			if (expected_hsv.size() == 0) begin
				$error("unexpected word: hue %0d saturation %0d brightness %0d", h, s, v);
				mismatches++;
				return;
			end
			want = expected_hsv.pop_front();
			if (h !== want.hue) begin
				$error("hue: expected %0d, got %0d", want.hue, h);
				mismatches++;
			end
			if (s !== want.saturation) begin
				$error("saturation: expected %0d, got %0d", want.saturation, s);
				mismatches++;
			end
			if (v !== want.brightness) begin
				$error("brightness: expected %0d, got %0d", want.brightness, v);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_hsv.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [CH-1:0] red = '0;
	logic [CH-1:0] green = '0;
	logic [CH-1:0] blue = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [FB-1:0] hue;
	logic [FB:0]   saturation;
	logic [CH-1:0] brightness;

	bit            tx_steady = 1'b0;
	bit            rx_steady = 1'b0;
	int            cycle_count = 0;
	hsv_scoreboard sb = new();

	rgb_to_hsv_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** rgb_to_hsv_pixel: FAILED **");
			$finish;
		end
	end

	task automatic send_pixel(logic [3*CH-1:0] px);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{red, green, blue} <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px[3*CH-1:2*CH], px[2*CH-1:CH], px[CH-1:0]);
	endtask

	function automatic logic [3*CH-1:0] random_pixel();
		int            kind;
		logic [CH-1:0] a;
		logic [CH-1:0] b;
		logic [CH-1:0] c [3];
		kind = $urandom_range(99);
		a = CH'($urandom_range(255));
		b = CH'($urandom_range(255));
		if (kind < 60)
			return (3*CH)'($urandom());
		if (kind < 75)
			return {a, a, a};
		if (kind < 90) begin
			// two channels tied, the third free
			case ($urandom_range(2))
				0: return {b, a, a};
				1: return {a, b, a};
				default: return {a, a, b};
			endcase
		end
		for (int i = 0; i < 3; i++)
			c[i] = $urandom_range(1) ? CH'($urandom_range(3)) : CH'(255 - $urandom_range(3));
		return {c[0], c[1], c[2]};
	endfunction

	// result side
	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_pixel(hue, saturation, brightness);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_pixel(DIRECTED[i]);

		for (int blk = 0; blk < RANDOM_PIXELS / BLOCK_PIXELS; blk++) begin
			tx_steady = ($urandom_range(3) == 0);
			rx_steady = ($urandom_range(3) == 0);
			if (blk == 2) begin
				// let the pipe drain completely before going on
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			for (int i = 0; i < BLOCK_PIXELS; i++)
				send_pixel(random_pixel());
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (FB + 10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("** rgb_to_hsv_pixel: PASSED **");
		else
			$display("** rgb_to_hsv_pixel: FAILED **");
		$finish;
	end

endmodule
